// ===== src/at_response_tokenizer_macros.svh =====
// Assertion helpers for the tokenizer checker.
`ifndef AT_RESPONSE_TOKENIZER_MACROS_SVH
`define AT_RESPONSE_TOKENIZER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ATRT_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tokenizer check failed");

// Next-cycle implication, disabled while reset is high.
`define ATRT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tokenizer check failed");

// Next-cycle implication that is also checked across reset.
`define ATRT_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("tokenizer check failed");

`endif

// ===== src/atrt_pkg.sv =====
`timescale 1ns / 1ps

package atrt_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_NAME = 2'd1,
    MODE_ARGS = 2'd2,
    MODE_LINE = 2'd3
  } mode_t;

  localparam logic [2:0] KIND_LINE_CHAR = 3'd0;
  localparam logic [2:0] KIND_LINE_END  = 3'd1;
  localparam logic [2:0] KIND_NAME_CHAR = 3'd2;
  localparam logic [2:0] KIND_NAME_END  = 3'd3;
  localparam logic [2:0] KIND_ARG_CHAR  = 3'd4;
  localparam logic [2:0] KIND_ARG_END   = 3'd5;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ERROR   = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;
  localparam logic [1:0] ST_RESULT  = 2'd3;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam int OK_LEN    = 2;
  localparam int ERROR_LEN = 5;
  localparam logic [7:0] OK_TEXT [OK_LEN] = '{8'h4F, 8'h4B};
  localparam logic [7:0] ERROR_TEXT [ERROR_LEN] = '{8'h45, 8'h52, 8'h52, 8'h4F, 8'h52};

  localparam int POS_W  = 9;
  localparam int ARGN_W = 4;
  localparam int TDATA_OUT_W = 24;

  typedef struct packed {
    mode_t               mode;
    logic [POS_W-1:0]    char_position;
    logic                ok_still_matches;
    logic                error_still_matches;
    logic                inside_quotes;
    logic                quoted_part_done;
    logic [ARGN_W-1:0]   arg_count;
  } parse_state_t;

  localparam parse_state_t RESET_STATE = '{
    mode:                MODE_IDLE,
    char_position:       '0,
    ok_still_matches:    1'b1,
    error_still_matches: 1'b1,
    inside_quotes:       1'b0,
    quoted_part_done:    1'b0,
    arg_count:           '0
  };

  typedef struct packed {
    logic [2:0]        kind;
    logic [7:0]        out_char;
    logic [POS_W-1:0]  position;
    logic [1:0]        status;
    logic [ARGN_W-1:0] arg_number;
    logic              closed_by_cr;
  } token_t;

endpackage

// ===== src/at_response_tokenizer.sv =====
`timescale 1ns / 1ps

// Modem response tokenizer.
// Slave stream (s_*): one received byte per transfer, s_tdata[7:0] = in_byte.
// Master stream (m_*): one token per transfer for every byte that is kept or
// that closes a line, a result name or an argument; m_tuser carries the token
// kind, m_tlast flags an argument closed by carriage return.
// Dropped bytes (idle line endings, the leading plus, unquoted spaces, quote
// marks, text after a closing quote) give no master transfer.
// Path: a byte accepted into the input register is stepped into the token
// register once that register is free or drained; it drives m_tvalid.
// Throughput: one byte per cycle unless the receiver stalls; the parse step is
// a single pass of logic between the input register and the token register.
// A held token blocks input only while it is not being drained: the input
// register still loads while the token register is free or drained.
// When the receiver stalls both registers fill and s_tready falls; nothing
// is lost or repeated.
// Reset (rst, synchronous, active high) empties both registers and returns
// the parser to idle with positions and the argument count at zero.
module at_response_tokenizer #(
  parameter int MAX_TEXT = 512
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [atrt_pkg::TDATA_OUT_W-1:0] m_tdata,
    // [7:0] out_char, [16:8] position, [18:17] status, [22:19] arg_number,
    // [23] zero
  output logic [2:0]  m_tuser,   // [2:0] kind
  output logic        m_tlast    // closed_by_cr
);

  // Input register
  logic       in_valid;
  logic [7:0] in_byte;

  // Parser state and step results
  atrt_pkg::parse_state_t state;
  atrt_pkg::parse_state_t state_next;
  logic                   tok_valid;
  atrt_pkg::token_t       tok;

  // Token register
  logic             out_valid;
  atrt_pkg::token_t out_tok;

  logic advance;

  // Step the held byte whenever the token register can take a result.
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  atrt_step #(
    .MAX_TEXT(MAX_TEXT)
  ) u_step (
    .cur       (state),
    .in_byte   (in_byte),
    .nxt       (state_next),
    .tok_valid (tok_valid),
    .tok       (tok)
  );

  // Hold the byte until it is stepped; load a fresh one on every transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  // Parser state: advance only when the byte is consumed.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= atrt_pkg::RESET_STATE;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Token register: load a new token, else drop the one just taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && tok_valid) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && tok_valid) begin
      out_tok <= tok;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_tok.arg_number, out_tok.status, out_tok.position,
                     out_tok.out_char};
  assign m_tuser  = out_tok.kind;
  assign m_tlast  = out_tok.closed_by_cr;

endmodule

// ===== src/atrt_step.sv =====
`timescale 1ns / 1ps

// Per-byte parse step: next state and the optional token for one byte.
module atrt_step #(
  parameter int MAX_TEXT = 512
) (
  input  atrt_pkg::parse_state_t cur,
  input  logic [7:0]             in_byte,
  output atrt_pkg::parse_state_t nxt,
  output logic                   tok_valid,
  output atrt_pkg::token_t       tok
);

  localparam int LIMIT_INT = ((MAX_TEXT - 1) > 511) ? 511 : (MAX_TEXT - 1);
  localparam logic [atrt_pkg::POS_W-1:0] POS_LIMIT = atrt_pkg::POS_W'(LIMIT_INT);

  logic [atrt_pkg::POS_W-1:0] pos;
  logic [atrt_pkg::POS_W-1:0] pos_inc;
  logic                       is_eol;
  logic                       ok_hit;
  logic                       err_hit;

  assign pos     = cur.char_position;
  assign pos_inc = (pos < POS_LIMIT) ? pos + atrt_pkg::POS_W'(1) : pos;
  assign is_eol  = in_byte inside {atrt_pkg::CH_CR, atrt_pkg::CH_LF};

  // Incremental match of the current line character against the two replies.
  assign ok_hit  = (pos < atrt_pkg::POS_W'(atrt_pkg::OK_LEN)) &&
                   (in_byte == atrt_pkg::OK_TEXT[pos[0]]);
  assign err_hit = (pos < atrt_pkg::POS_W'(atrt_pkg::ERROR_LEN)) &&
                   (in_byte == atrt_pkg::ERROR_TEXT[pos[2:0]]);

  always_comb begin
    nxt       = cur;
    tok_valid = 1'b0;
    tok       = '0;
    tok.out_char = in_byte;
    tok.position = pos;

    case (cur.mode)
      atrt_pkg::MODE_IDLE: begin
        if (is_eol) begin
          // skip blank line endings
        end else if (in_byte == atrt_pkg::CH_PLUS) begin
          nxt.mode          = atrt_pkg::MODE_NAME;
          nxt.char_position = '0;
        end else begin
          // first character of a plain line: position is zero here
          nxt.mode                = atrt_pkg::MODE_LINE;
          nxt.ok_still_matches    = (in_byte == atrt_pkg::OK_TEXT[0]);
          nxt.error_still_matches = (in_byte == atrt_pkg::ERROR_TEXT[0]);
          nxt.char_position       = (POS_LIMIT > '0) ? atrt_pkg::POS_W'(1) : '0;
          tok_valid               = 1'b1;
          tok.kind                = atrt_pkg::KIND_LINE_CHAR;
          tok.position            = '0;
        end
      end

      atrt_pkg::MODE_LINE: begin
        tok_valid = 1'b1;
        if (is_eol) begin
          tok.kind = atrt_pkg::KIND_LINE_END;
          if (in_byte == atrt_pkg::CH_CR && cur.ok_still_matches &&
              pos == atrt_pkg::POS_W'(atrt_pkg::OK_LEN)) begin
            tok.status = atrt_pkg::ST_OK;
          end else if (in_byte == atrt_pkg::CH_CR && cur.error_still_matches &&
                       pos == atrt_pkg::POS_W'(atrt_pkg::ERROR_LEN)) begin
            tok.status = atrt_pkg::ST_ERROR;
          end else begin
            tok.status = atrt_pkg::ST_UNKNOWN;
          end
          nxt.mode          = atrt_pkg::MODE_IDLE;
          nxt.char_position = '0;
        end else begin
          tok.kind                = atrt_pkg::KIND_LINE_CHAR;
          nxt.ok_still_matches    = cur.ok_still_matches && ok_hit;
          nxt.error_still_matches = cur.error_still_matches && err_hit;
          nxt.char_position       = pos_inc;
        end
      end

      atrt_pkg::MODE_NAME: begin
        tok_valid = 1'b1;
        if (in_byte == atrt_pkg::CH_COLON) begin
          tok.kind              = atrt_pkg::KIND_NAME_END;
          tok.status            = atrt_pkg::ST_RESULT;
          nxt.mode              = atrt_pkg::MODE_ARGS;
          nxt.arg_count         = '0;
          nxt.char_position     = '0;
          nxt.inside_quotes     = 1'b0;
          nxt.quoted_part_done  = 1'b0;
        end else begin
          tok.kind          = atrt_pkg::KIND_NAME_CHAR;
          nxt.char_position = pos_inc;
        end
      end

      atrt_pkg::MODE_ARGS: begin
        tok.arg_number = cur.arg_count;
        if (in_byte == atrt_pkg::CH_CR) begin
          tok_valid            = 1'b1;
          tok.kind             = atrt_pkg::KIND_ARG_END;
          tok.status           = atrt_pkg::ST_RESULT;
          tok.closed_by_cr     = 1'b1;
          nxt.mode             = atrt_pkg::MODE_IDLE;
          nxt.char_position    = '0;
          nxt.inside_quotes    = 1'b0;
          nxt.quoted_part_done = 1'b0;
          nxt.arg_count        = '0;
        end else if (!cur.inside_quotes && in_byte == atrt_pkg::CH_COMMA) begin
          tok_valid            = 1'b1;
          tok.kind             = atrt_pkg::KIND_ARG_END;
          tok.status           = atrt_pkg::ST_RESULT;
          nxt.arg_count        = (&cur.arg_count) ? cur.arg_count
                                                  : cur.arg_count + atrt_pkg::ARGN_W'(1);
          nxt.char_position    = '0;
          nxt.inside_quotes    = 1'b0;
          nxt.quoted_part_done = 1'b0;
        end else if (cur.quoted_part_done) begin
          // drop trailing bytes after the closing quote
        end else if (in_byte == atrt_pkg::CH_QUOTE) begin
          nxt.inside_quotes    = !cur.inside_quotes;
          nxt.quoted_part_done = cur.inside_quotes;
        end else if (!cur.inside_quotes && in_byte == atrt_pkg::CH_SPACE) begin
          // drop unquoted spaces
        end else begin
          tok_valid         = 1'b1;
          tok.kind          = atrt_pkg::KIND_ARG_CHAR;
          nxt.char_position = pos_inc;
        end
      end

      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

// ===== src/atrt_checker.sv =====
`timescale 1ns / 1ps
`include "at_response_tokenizer_macros.svh"

// Port-level checks on the tokenizer's master stream.
module atrt_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic [2:0]  m_tuser,
  input logic        m_tlast
);

  `ATRT_ASSERT_NEXT_ALWAYS(a_reset_empties, clk, rst, !m_tvalid)

  `ATRT_ASSERT_NEXT(a_stall_holds, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

  `ATRT_ASSERT_IMPLIES(a_last_on_arg_end, clk, rst, m_tvalid && m_tlast, m_tuser == atrt_pkg::KIND_ARG_END && m_tdata[7:0] == atrt_pkg::CH_CR)

  `ATRT_ASSERT_IMPLIES(a_char_status_zero, clk, rst, m_tvalid && (m_tuser == atrt_pkg::KIND_LINE_CHAR || m_tuser == atrt_pkg::KIND_NAME_CHAR || m_tuser == atrt_pkg::KIND_ARG_CHAR), m_tdata[18:17] == atrt_pkg::ST_OK && !m_tlast)

  `ATRT_ASSERT_IMPLIES(a_result_status, clk, rst, m_tvalid && (m_tuser == atrt_pkg::KIND_NAME_END || m_tuser == atrt_pkg::KIND_ARG_END), m_tdata[18:17] == atrt_pkg::ST_RESULT)

endmodule

bind at_response_tokenizer atrt_checker u_atrt_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int MAX_TEXT     = 512;
  localparam int POS_MAX      = (MAX_TEXT - 1 > 511) ? 511 : MAX_TEXT - 1;
  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 12;
  localparam int RANDOM_BYTES = 150;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 300000;

  // How a byte's outcome is obtained: from the parser copy below, typed into
  // the opening table, or known to give no token at all.
  typedef enum logic [1:0] {
    CHK_MODEL = 2'd0,
    CHK_TABLE = 2'd1,
    CHK_NONE  = 2'd2
  } chk_t;

  typedef struct packed {
    logic [7:0]       b;
    chk_t             how;
    atrt_pkg::token_t tok;
  } stim_row_t;

  // Opening sequence: idle line endings, OK and ERROR lines, the byte
  // extremes, then a result line with quoting, trailing junk after a closing
  // quote and a comma kept inside quotes.
  localparam int OPENING_LEN = 26;
  localparam stim_row_t OPENING_SCRIPT [OPENING_LEN] = '{
    '{atrt_pkg::CH_CR,    CHK_NONE,  '0},
    '{atrt_pkg::CH_LF,    CHK_NONE,  '0},
    '{8'h4F,              CHK_TABLE,
      '{atrt_pkg::KIND_LINE_CHAR, 8'h4F, 9'd0, atrt_pkg::ST_OK, 4'd0, 1'b0}},
    '{8'h4B,              CHK_MODEL, '0},
    '{atrt_pkg::CH_CR,    CHK_TABLE,
      '{atrt_pkg::KIND_LINE_END, atrt_pkg::CH_CR, 9'd2, atrt_pkg::ST_OK, 4'd0, 1'b0}},
    '{8'h45,              CHK_MODEL, '0},
    '{8'h52,              CHK_MODEL, '0},
    '{8'h52,              CHK_MODEL, '0},
    '{8'h4F,              CHK_MODEL, '0},
    '{8'h52,              CHK_MODEL, '0},
    '{atrt_pkg::CH_CR,    CHK_TABLE,
      '{atrt_pkg::KIND_LINE_END, atrt_pkg::CH_CR, 9'd5, atrt_pkg::ST_ERROR, 4'd0, 1'b0}},
    '{8'h00,              CHK_TABLE,
      '{atrt_pkg::KIND_LINE_CHAR, 8'h00, 9'd0, atrt_pkg::ST_OK, 4'd0, 1'b0}},
    '{8'hFF,              CHK_MODEL, '0},
    '{atrt_pkg::CH_LF,    CHK_TABLE,
      '{atrt_pkg::KIND_LINE_END, atrt_pkg::CH_LF, 9'd2, atrt_pkg::ST_UNKNOWN, 4'd0, 1'b0}},
    '{atrt_pkg::CH_PLUS,  CHK_NONE,  '0},
    '{8'h43,              CHK_MODEL, '0},
    '{atrt_pkg::CH_CR,    CHK_MODEL, '0},
    '{atrt_pkg::CH_COLON, CHK_MODEL, '0},
    '{atrt_pkg::CH_SPACE, CHK_NONE,  '0},
    '{atrt_pkg::CH_QUOTE, CHK_NONE,  '0},
    '{atrt_pkg::CH_COMMA, CHK_MODEL, '0},
    '{atrt_pkg::CH_QUOTE, CHK_NONE,  '0},
    '{8'h78,              CHK_NONE,  '0},
    '{atrt_pkg::CH_COMMA, CHK_MODEL, '0},
    '{8'h61,              CHK_MODEL, '0},
    '{atrt_pkg::CH_CR,    CHK_MODEL, '0}
  };

  logic                             clk = 1'b0;
  logic                             rst;
  logic                             s_tvalid;
  logic                             s_tready;
  logic [7:0]                       s_tdata;   // [7:0] in_byte
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [atrt_pkg::TDATA_OUT_W-1:0] m_tdata;
    // [7:0] out_char, [16:8] position, [18:17] status, [22:19] arg_number,
    // [23] zero
  logic [2:0]                       m_tuser;   // [2:0] kind
  logic                             m_tlast;   // closed_by_cr

  // Parser copy: the tokenizer state as seen from outside.
  atrt_pkg::mode_t rx_mode      = atrt_pkg::MODE_IDLE;
  logic [8:0]      col          = '0;
  logic            ok_live      = 1'b1;
  logic            err_live     = 1'b1;
  logic            in_quotes    = 1'b0;
  logic            quote_closed = 1'b0;
  logic [3:0]      arg_idx      = '0;

  stim_row_t        pending_bytes [$];
  atrt_pkg::token_t expected_tokens [$];
  logic [7:0]       frame_q [$];

  int errors = 0;
  int sent_bytes = 0;
  int tokens_out = 0;
  int lines_ok = 0, lines_err = 0, lines_unk = 0;
  int names_seen = 0, args_seen = 0, last_args = 0;
  int stall_run = 0, stall_max = 0;
  int cycle_cnt = 0;
  int burst_left = 0;

  // Receiver side state, owned by its own process.
  bit stall_request = 1'b0;
  bit stall_done = 1'b0;
  int hold_left = 0;
  int rx_pattern = 0;
  int pattern_left = 0;
  int rx_tick = 0;

  at_response_tokenizer #(
    .MAX_TEXT (MAX_TEXT)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #CLK_HALF clk = ~clk;

  // ---------------------------------------------------------------------
  // Parser copy helpers
  // ---------------------------------------------------------------------

  // Advance the character index, holding it at the saturation point.
  function automatic void bump_col();
    if (col < POS_MAX) col = col + 9'd1;
  endfunction

  function automatic void open_arg();
    col = '0;
    in_quotes = 1'b0;
    quote_closed = 1'b0;
  endfunction

  // Drop each candidate word as soon as a character departs from it.
  function automatic void match_text(input logic [7:0] b);
    if (!(col < atrt_pkg::OK_LEN && b == atrt_pkg::OK_TEXT[col[0]])) ok_live = 1'b0;
    if (!(col < atrt_pkg::ERROR_LEN && b == atrt_pkg::ERROR_TEXT[col[2:0]]))
      err_live = 1'b0;
  endfunction

  // Feed one byte; returns 1 with the token when the byte yields one.
  function automatic bit tokenize(input logic [7:0] b, output atrt_pkg::token_t t);
    logic [8:0] at;
    logic [1:0] st;
    at = col;
    t = '0;
    case (rx_mode)
      atrt_pkg::MODE_IDLE: begin
        if (b == atrt_pkg::CH_CR || b == atrt_pkg::CH_LF) return 1'b0;
        if (b == atrt_pkg::CH_PLUS) begin
          rx_mode = atrt_pkg::MODE_NAME;
          col = '0;
          return 1'b0;
        end
        rx_mode = atrt_pkg::MODE_LINE;
        col = '0;
        ok_live = 1'b1;
        err_live = 1'b1;
        match_text(b);
        t = '{atrt_pkg::KIND_LINE_CHAR, b, 9'd0, atrt_pkg::ST_OK, 4'd0, 1'b0};
        bump_col();
        return 1'b1;
      end
      atrt_pkg::MODE_LINE: begin
        if (b == atrt_pkg::CH_CR || b == atrt_pkg::CH_LF) begin
          st = atrt_pkg::ST_UNKNOWN;
          if (b == atrt_pkg::CH_CR && ok_live && at == atrt_pkg::OK_LEN)
            st = atrt_pkg::ST_OK;
          else if (b == atrt_pkg::CH_CR && err_live && at == atrt_pkg::ERROR_LEN)
            st = atrt_pkg::ST_ERROR;
          t = '{atrt_pkg::KIND_LINE_END, b, at, st, 4'd0, 1'b0};
          rx_mode = atrt_pkg::MODE_IDLE;
          col = '0;
          return 1'b1;
        end
        match_text(b);
        t = '{atrt_pkg::KIND_LINE_CHAR, b, at, atrt_pkg::ST_OK, 4'd0, 1'b0};
        bump_col();
        return 1'b1;
      end
      atrt_pkg::MODE_NAME: begin
        if (b == atrt_pkg::CH_COLON) begin
          t = '{atrt_pkg::KIND_NAME_END, b, at, atrt_pkg::ST_RESULT, 4'd0, 1'b0};
          rx_mode = atrt_pkg::MODE_ARGS;
          arg_idx = '0;
          open_arg();
          return 1'b1;
        end
        t = '{atrt_pkg::KIND_NAME_CHAR, b, at, atrt_pkg::ST_OK, 4'd0, 1'b0};
        bump_col();
        return 1'b1;
      end
      default: begin
        // CR closes the argument even inside quotes.
        if (b == atrt_pkg::CH_CR) begin
          t = '{atrt_pkg::KIND_ARG_END, b, at, atrt_pkg::ST_RESULT, arg_idx, 1'b1};
          rx_mode = atrt_pkg::MODE_IDLE;
          open_arg();
          arg_idx = '0;
          return 1'b1;
        end
        if (!in_quotes && b == atrt_pkg::CH_COMMA) begin
          t = '{atrt_pkg::KIND_ARG_END, b, at, atrt_pkg::ST_RESULT, arg_idx, 1'b0};
          if (arg_idx != 4'hF) arg_idx = arg_idx + 4'd1;
          open_arg();
          return 1'b1;
        end
        // Drop everything after a closing quote.
        if (quote_closed) return 1'b0;
        if (b == atrt_pkg::CH_QUOTE) begin
          if (in_quotes) begin
            in_quotes = 1'b0;
            quote_closed = 1'b1;
          end else begin
            in_quotes = 1'b1;
          end
          return 1'b0;
        end
        if (!in_quotes && b == atrt_pkg::CH_SPACE) return 1'b0;
        t = '{atrt_pkg::KIND_ARG_CHAR, b, at, atrt_pkg::ST_OK, arg_idx, 1'b0};
        bump_col();
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------

  // Offer one byte at the falling edge and hold it until transferred. The
  // sender runs in bursts; between bursts it may drop valid, except while
  // the receiver is holding off, so that the block fills up.
  task automatic drive_byte(input logic [7:0] b, input chk_t how,
                            input atrt_pkg::token_t tok);
    stim_row_t row;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (hold_left == 0 && $urandom_range(0, 2) != 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
    burst_left--;
    row = '{b, how, tok};
    pending_bytes.push_back(row);
    s_tdata <= b;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (s_tready !== 1'b1);
    sent_bytes++;
    @(negedge clk);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) frame_q.push_back(s[i]);
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) drive_byte(frame_q[i], CHK_MODEL, '0);
    frame_q.delete();
  endtask

  // Mostly letters and digits, now and then any byte at all.
  function automatic logic [7:0] word_char();
    case ($urandom_range(0, 9))
      0:       return 8'($urandom_range(0, 255));
      1, 2:    return 8'($urandom_range(8'h30, 8'h39));
      3, 4, 5: return 8'($urandom_range(8'h41, 8'h5A));
      default: return 8'($urandom_range(8'h61, 8'h7A));
    endcase
  endfunction

  // Append one argument body: plain text, quoted text (with commas, spaces
  // and the odd junk after the closing quote) or an empty field.
  task automatic add_arg(input bit final_arg);
    int n;
    repeat ($urandom_range(0, 2)) frame_q.push_back(atrt_pkg::CH_SPACE);
    case ($urandom_range(0, 5))
      0: ;
      1, 2: begin
        n = $urandom_range(1, 6);
        repeat (n) begin
          if ($urandom_range(0, 7) == 0) frame_q.push_back(atrt_pkg::CH_SPACE);
          else frame_q.push_back(word_char());
        end
      end
      3, 4: begin
        frame_q.push_back(atrt_pkg::CH_QUOTE);
        repeat ($urandom_range(0, 8)) begin
          case ($urandom_range(0, 5))
            0:       frame_q.push_back(atrt_pkg::CH_COMMA);
            1:       frame_q.push_back(atrt_pkg::CH_SPACE);
            default: frame_q.push_back(word_char());
          endcase
        end
        frame_q.push_back(atrt_pkg::CH_QUOTE);
        if ($urandom_range(0, 2) == 0)
          repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(0, 3))
              0:       frame_q.push_back(atrt_pkg::CH_QUOTE);
              1:       frame_q.push_back(atrt_pkg::CH_SPACE);
              default: frame_q.push_back(8'($urandom_range(8'h41, 8'h5A)));
            endcase
          end
      end
      default: begin
        // Unterminated quote: only CR can close it, so keep it last.
        if (final_arg) begin
          frame_q.push_back(atrt_pkg::CH_QUOTE);
          repeat ($urandom_range(0, 6)) begin
            if ($urandom_range(0, 2) == 0) frame_q.push_back(atrt_pkg::CH_COMMA);
            else frame_q.push_back(word_char());
          end
        end else begin
          frame_q.push_back(word_char());
        end
      end
    endcase
  endtask

  // Build one random response fragment into the frame queue.
  task automatic build_random_frame();
    int nargs;
    case ($urandom_range(0, 11))
      0, 1: begin
        case ($urandom_range(0, 3))
          0:       push_text("OK\n");
          1:       push_text("OKK\r");
          2:       push_text("O\r");
          default: push_text("OK\r");
        endcase
        if ($urandom_range(0, 1)) frame_q.push_back(atrt_pkg::CH_LF);
      end
      2: begin
        case ($urandom_range(0, 3))
          0:       push_text("ERRO\r");
          1:       push_text("ERRORX\r");
          2:       push_text("ERROR\n");
          default: push_text("ERROR\r");
        endcase
        if ($urandom_range(0, 1)) frame_q.push_back(atrt_pkg::CH_LF);
      end
      3, 4: begin
        if ($urandom_range(0, 2) == 0) frame_q.push_back(atrt_pkg::CH_LF);
        repeat ($urandom_range(1, 20)) begin
          if ($urandom_range(0, 6) == 0) frame_q.push_back(atrt_pkg::CH_SPACE);
          else frame_q.push_back(word_char());
        end
        frame_q.push_back($urandom_range(0, 1) ? atrt_pkg::CH_CR : atrt_pkg::CH_LF);
      end
      5, 6, 7, 8: begin
        frame_q.push_back(atrt_pkg::CH_PLUS);
        repeat ($urandom_range(1, 6)) frame_q.push_back(word_char());
        frame_q.push_back(atrt_pkg::CH_COLON);
        nargs = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 20) : $urandom_range(1, 5);
        for (int i = 0; i < nargs; i++) begin
          add_arg(i == nargs - 1);
          frame_q.push_back(i == nargs - 1 ? atrt_pkg::CH_CR : atrt_pkg::CH_COMMA);
        end
        if ($urandom_range(0, 1)) frame_q.push_back(atrt_pkg::CH_LF);
        if ($urandom_range(0, 1)) push_text("\r\nOK\r\n");
      end
      9: begin
        // Broken result: line endings inside the name, no argument text.
        push_text("+CS\r\nQ:");
        frame_q.push_back(atrt_pkg::CH_CR);
      end
      10: repeat ($urandom_range(1, 10)) frame_q.push_back(8'($urandom_range(0, 255)));
      default: repeat ($urandom_range(1, 4))
        frame_q.push_back($urandom_range(0, 1) ? atrt_pkg::CH_CR : atrt_pkg::CH_LF);
    endcase
  endtask

  // ---------------------------------------------------------------------
  // Receiver side: change stall pattern now and then; once asked, hold off
  // for a long stretch so that both stages fill and s_tready falls.
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (stall_request && !stall_done) begin
      hold_left = HOLD_CYCLES;
      stall_done = 1'b1;
    end
    if (pattern_left == 0) begin
      rx_pattern = $urandom_range(0, 3);
      pattern_left = $urandom_range(20, 120);
    end else begin
      pattern_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      case (rx_pattern)
        0:       m_tready <= 1'b1;
        1:       m_tready <= 1'($urandom_range(0, 1));
        2:       m_tready <= ($urandom_range(0, 7) != 0);
        default: m_tready <= (rx_tick % 4 == 0);
      endcase
    end
    rx_tick++;
  end

  // ---------------------------------------------------------------------
  // Scoreboard: compare each token transfer with the oldest expectation,
  // then run the parser copy on each byte transfer. A token never comes out
  // in the same cycle as the byte that caused it, so the order is safe.
  // ---------------------------------------------------------------------
  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : scoreboard
    atrt_pkg::token_t got;
    atrt_pkg::token_t want;
    atrt_pkg::token_t t;
    stim_row_t        row;
    bit               made;
    if (!rst && m_tvalid && m_tready) begin
      got = '{m_tuser, m_tdata[7:0], m_tdata[16:8], m_tdata[18:17], m_tdata[22:19],
              m_tlast};
      tokens_out++;
      if (expected_tokens.size() == 0) begin
        $error("unexpected token: kind %0d char 0x%0h", got.kind, got.out_char);
        errors++;
      end else begin
        want = expected_tokens.pop_front();
        check_field("kind", 32'(want.kind), 32'(got.kind));
        check_field("out_char", 32'(want.out_char), 32'(got.out_char));
        check_field("position", 32'(want.position), 32'(got.position));
        check_field("status", 32'(want.status), 32'(got.status));
        check_field("arg_number", 32'(want.arg_number), 32'(got.arg_number));
        check_field("closed_by_cr", 32'(want.closed_by_cr), 32'(got.closed_by_cr));
        check_field("tdata pad", 0, 32'(m_tdata[23]));
        if (got.kind == atrt_pkg::KIND_LINE_END) begin
          if (got.status == atrt_pkg::ST_OK) lines_ok++;
          else if (got.status == atrt_pkg::ST_ERROR) lines_err++;
          else lines_unk++;
        end
        if (got.kind == atrt_pkg::KIND_NAME_END) names_seen++;
        if (got.kind == atrt_pkg::KIND_ARG_END) begin
          args_seen++;
          if (got.closed_by_cr) last_args++;
        end
      end
    end
    if (!rst && s_tvalid && s_tready) begin
      row = pending_bytes.pop_front();
      made = tokenize(s_tdata, t);
      if (row.how == CHK_TABLE) expected_tokens.push_back(row.tok);
      else if (row.how == CHK_MODEL && made) expected_tokens.push_back(t);
    end
    // Track the longest run of input back-pressure.
    if (!rst && s_tvalid && !s_tready) begin
      stall_run++;
      if (stall_run > stall_max) stall_max = stall_run;
    end else begin
      stall_run = 0;
    end
  end

  // Watchdog.
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("testbench NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin : main
    int random_start;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed opening, walked row by row.
    foreach (OPENING_SCRIPT[i])
      drive_byte(OPENING_SCRIPT[i].b, OPENING_SCRIPT[i].how, OPENING_SCRIPT[i].tok);

    // Ask the receiver for its long hold-off while the sender keeps going.
    stall_request = 1'b1;

    // Saturation case: a plain line longer than the position range.
    repeat ($urandom_range(513, 520)) frame_q.push_back(8'($urandom_range(8'h41, 8'h5A)));
    frame_q.push_back(atrt_pkg::CH_CR);
    send_frame();

    // Random responses until the byte budget is used up.
    random_start = sent_bytes;
    while (sent_bytes - random_start < RANDOM_BYTES) begin
      build_random_frame();
      send_frame();
    end

    // Drain: wait for every expected token, then wait out DRAIN_CYCLES to catch
    // anything extra.
    s_tvalid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d bytes and %0d tokens: lines ok %0d, error %0d, unknown %0d;",
             sent_bytes, tokens_out, lines_ok, lines_err, lines_unk);
    $display("%0d names, %0d arguments (%0d closed by CR), longest input stall %0d cycles.",
             names_seen, args_seen, last_args, stall_max);
    if (errors == 0 && expected_tokens.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
